[sv/brf_pkg.sv]
// brf_pkg: shared types, codes and sizes for the batch ring FIFO.
// Used by brf_front, brf_back, batch_ring_fifo_unit and the testbench; no dependencies.
package brf_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int IDX_W     = 7;
    localparam int CNT_W     = 7;
    localparam int ENTRY_W   = 64;
    localparam int QDEPTH    = 2;
    localparam int Q_AW      = 1;

    // input modes
    localparam logic [2:0] MODE_PUSH  = 3'd0;
    localparam logic [2:0] MODE_POP   = 3'd1;
    localparam logic [2:0] MODE_PEEK  = 3'd2;
    localparam logic [2:0] MODE_FLUSH = 3'd3;

    // decoded operations
    localparam logic [2:0] OP_QUERY = 3'd0;
    localparam logic [2:0] OP_PUSH  = 3'd1;
    localparam logic [2:0] OP_POP   = 3'd2;
    localparam logic [2:0] OP_PEEK  = 3'd3;
    localparam logic [2:0] OP_FLUSH = 3'd4;

    // result status
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOROOM = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    typedef struct packed {
        logic [2:0]         op;
        logic [ENTRY_W-1:0] entry;
        logic [CNT_W-1:0]   count;
        logic               start;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic [ENTRY_W-1:0] out_entry;
        logic [IDX_W-1:0]   level;
        logic               last;
    } t_res;

endpackage

[sv/brf_front.sv]
// brf_front: accepts requests, decodes them into commands and queues them.
// Depends on brf_pkg.
module brf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [2:0]    i_mode,
    input  logic [brf_pkg::ENTRY_W-1:0] i_entry,
    input  logic [brf_pkg::CNT_W-1:0]   i_count,
    input  logic          i_start,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output brf_pkg::t_cmd o_cmd
);

    brf_pkg::t_cmd              w_cmd;
    brf_pkg::t_cmd              r_q [brf_pkg::QDEPTH];
    logic [brf_pkg::Q_AW-1:0]   r_wp, r_rp;
    logic [brf_pkg::Q_AW:0]     r_cnt;
    logic                       w_push, w_pop;

    always_comb begin
        w_cmd.entry = i_entry;
        w_cmd.count = i_count;
        w_cmd.start = i_start;
        case (i_mode)
            brf_pkg::MODE_PUSH:  w_cmd.op = brf_pkg::OP_PUSH;
            brf_pkg::MODE_POP:   w_cmd.op = (i_count == '0) ? brf_pkg::OP_QUERY
                                                             : brf_pkg::OP_POP;
            brf_pkg::MODE_PEEK:  w_cmd.op = (i_count == '0) ? brf_pkg::OP_QUERY
                                                             : brf_pkg::OP_PEEK;
            brf_pkg::MODE_FLUSH: w_cmd.op = brf_pkg::OP_FLUSH;
            default:             w_cmd.op = brf_pkg::OP_QUERY;
        endcase
    end

    assign o_ready     = (r_cnt != (brf_pkg::Q_AW+1)'(brf_pkg::QDEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[sv/brf_back.sv]
// brf_back: executes queued commands on the slot memory and ring indices,
// and holds the result register. Depends on brf_pkg.
module brf_back #(
    parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  brf_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output brf_pkg::t_res o_res
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [brf_pkg::IDX_W:0] DepthW = (brf_pkg::IDX_W+1)'(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SEND = 2'd2;

    logic [brf_pkg::ENTRY_W-1:0] r_mem [DEPTH];
    logic [brf_pkg::ENTRY_W-1:0] r_rdata;

    logic [1:0]                r_state, n_state;
    logic [brf_pkg::IDX_W-1:0] r_ri, n_ri, r_wi, n_wi;
    logic                      r_rej, n_rej;
    logic [brf_pkg::IDX_W-1:0] r_ptr, n_ptr, r_rem, n_rem, r_after, n_after;
    logic                      r_is_pop, n_is_pop;
    logic                      r_out_valid, n_out_valid;
    brf_pkg::t_res             r_out, n_out;

    logic [brf_pkg::IDX_W-1:0] w_lvl, w_n;
    logic                      w_out_free, w_rej, w_full, w_wr;

    assign w_lvl      = r_wi - r_ri;
    assign w_n        = (w_lvl < i_cmd.count) ? w_lvl : i_cmd.count;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_rej      = i_cmd.start ? (({1'b0, w_lvl} + {1'b0, i_cmd.count}) > DepthW)
                                    : r_rej;
    assign w_full     = ({1'b0, w_lvl} >= DepthW);
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;

    always_comb begin
        n_state     = r_state;
        n_ri        = r_ri;
        n_wi        = r_wi;
        n_rej       = r_rej;
        n_ptr       = r_ptr;
        n_rem       = r_rem;
        n_after     = r_after;
        n_is_pop    = r_is_pop;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        o_cmd_ready = 1'b0;
        w_wr        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_cmd_ready         = 1'b1;
                    n_out_valid         = 1'b1;
                    n_out.status        = brf_pkg::ST_OK;
                    n_out.out_entry     = '0;
                    n_out.level         = w_lvl;
                    n_out.last          = 1'b1;
                    case (i_cmd.op)
                        brf_pkg::OP_PUSH: begin
                            n_rej = w_rej;
                            if (w_rej || w_full) begin
                                n_out.status = brf_pkg::ST_NOROOM;
                            end else begin
                                w_wr        = 1'b1;
                                n_wi        = r_wi + 1'b1;
                                n_out.level = w_lvl + 1'b1;
                            end
                        end
                        brf_pkg::OP_POP, brf_pkg::OP_PEEK: begin
                            if (w_lvl == '0) begin
                                n_out.status = brf_pkg::ST_EMPTY;
                            end else begin
                                n_out_valid = r_out_valid && !i_ready;
                                n_out       = r_out;
                                n_ptr       = r_ri;
                                n_rem       = w_n;
                                n_is_pop    = (i_cmd.op == brf_pkg::OP_POP);
                                n_after     = (i_cmd.op == brf_pkg::OP_POP) ? w_lvl - w_n
                                                                            : w_lvl;
                                n_state     = S_READ;
                            end
                        end
                        brf_pkg::OP_FLUSH: begin
                            n_ri        = r_ri + w_n;
                            n_out.level = w_lvl - w_n;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (w_out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.status    = brf_pkg::ST_OK;
                    n_out.out_entry = r_rdata;
                    n_out.level     = r_after;
                    n_out.last      = (r_rem == 7'd1);
                    n_ptr           = r_ptr + 1'b1;
                    n_rem           = r_rem - 1'b1;
                    if (r_rem == 7'd1) begin
                        if (r_is_pop) begin
                            n_ri = r_ptr + 1'b1;
                        end
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wi[AW-1:0]] <= i_cmd.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_ptr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ri        <= '0;
            r_wi        <= '0;
            r_rej       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ri        <= n_ri;
            r_wi        <= n_wi;
            r_rej       <= n_rej;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_rem    <= n_rem;
        r_after  <= n_after;
        r_is_pop <= n_is_pop;
        r_out    <= n_out;
    end

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, w_lvl} <= DepthW))
        else $error("ring level above depth");
    a_ack_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_ready |-> (r_state == S_IDLE))
        else $error("command taken outside idle");
    a_send_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND) |-> (r_rem != '0))
        else $error("read burst with nothing left");
    a_wi_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_SEND) |=> $stable(r_wi))
        else $error("write index moved during read burst");
`endif

endmodule

[sv/batch_ring_fifo_unit.sv]
// batch_ring_fifo_unit: top level of the batch ring FIFO.
// Depends on brf_pkg, brf_front and brf_back.
//
//  channel  dir  tdata                          tuser                       tlast
//  s        in   [63:0] entry, [70:64] count    [2:0] mode, [3] batch_start -
//  m        out  [63:0] out_entry, [70:64] level [1:0] status                last
//
// Push, flush, query and empty or zero-count pop/peek finish in the idle state.
// Pop and peek are decoded in idle, then for each entry: memory read, then send.
// The queue registers each accepted request before the back end takes it.
// A two-entry command queue lets requests be accepted while the back end works.
// Reset is synchronous, active low; slot memory is not cleared.
// Output stalls hold the result register; the queue then fills and drops s_tready.
module batch_ring_fifo_unit #(
    parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // entry, count, pad
    input  logic [3:0]  i_s_tuser,   // mode, batch_start
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // out_entry, level, pad
    output logic [1:0]  o_m_tuser,   // status
    output logic        o_m_tlast
);

    logic          w_cmd_valid, w_cmd_ready;
    brf_pkg::t_cmd w_cmd;
    brf_pkg::t_res w_res;

    brf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_mode      (i_s_tuser[2:0]),
        .i_entry     (i_s_tdata[63:0]),
        .i_count     (i_s_tdata[70:64]),
        .i_start     (i_s_tuser[3]),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    brf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_res       (w_res)
    );

    assign o_m_tdata = {1'b0, w_res.level, w_res.out_entry};
    assign o_m_tuser = w_res.status;
    assign o_m_tlast = w_res.last;

endmodule

[bench/testbench.sv]
// testbench: self-checking bench for batch_ring_fifo_unit, random and directed requests.
// Depends on brf_pkg and the batch_ring_fifo_unit RTL; keeps its own ring model to predict results.
module testbench;

    localparam int         RING_DEPTH     = brf_pkg::DEPTH_DEF;
    localparam logic [2:0] MODE_QUERY     = 3'd4;
    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] handle;
        logic [6:0]  level;
        logic        last;
    } t_ring_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [71:0] i_s_tdata;
    logic [3:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [71:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    logic [63:0] ring_slots [RING_DEPTH];
    logic [6:0]  rd_idx;
    logic [6:0]  wr_idx;
    logic        batch_dropped;

    t_ring_result pending_results [$];
    int           mismatch_count;
    int           requests_sent;
    bit           source_gaps;
    bit           sink_stalls;

    batch_ring_fifo_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // entry, count, pad
        .i_s_tuser  (i_s_tuser),   // mode, batch_start
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // out_entry, level, pad
        .o_m_tuser  (o_m_tuser),   // status
        .o_m_tlast  (o_m_tlast)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [63:0] rand_handle();
        return {$urandom, $urandom};
    endfunction

    task automatic expect_result(input logic [1:0] st, input logic [63:0] h,
                                 input logic [6:0] lvl, input logic lst);
        t_ring_result r;
        r.status = st;
        r.handle = h;
        r.level  = lvl;
        r.last   = lst;
        pending_results.push_back(r);
    endtask

    task automatic predict_ring_step(input logic [2:0] mode, input logic [63:0] handle,
                                     input logic [6:0] count, input logic start);
        logic [6:0] lvl;
        logic [6:0] after;
        int         n;
        logic [1:0] st;
        lvl = wr_idx - rd_idx;
        n   = (int'(lvl) < int'(count)) ? int'(lvl) : int'(count);
        case (mode)
            brf_pkg::MODE_PUSH: begin
                if (start)
                    batch_dropped = (int'(lvl) + int'(count)) > RING_DEPTH;
                if (batch_dropped || int'(lvl) >= RING_DEPTH) begin
                    st = brf_pkg::ST_NOROOM;
                end else begin
                    ring_slots[int'(wr_idx) % RING_DEPTH] = handle;
                    wr_idx = wr_idx + 7'd1;
                    st = brf_pkg::ST_OK;
                end
                expect_result(st, '0, wr_idx - rd_idx, 1'b1);
            end
            brf_pkg::MODE_POP, brf_pkg::MODE_PEEK: begin
                if (count == 0) begin
                    expect_result(brf_pkg::ST_OK, '0, lvl, 1'b1);
                end else if (lvl == 0) begin
                    expect_result(brf_pkg::ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    after = (mode == brf_pkg::MODE_POP) ? lvl - 7'(n) : lvl;
                    for (int i = 0; i < n; i++)
                        expect_result(brf_pkg::ST_OK,
                                      ring_slots[(int'(rd_idx) + i) % RING_DEPTH],
                                      after, i == n - 1);
                    if (mode == brf_pkg::MODE_POP)
                        rd_idx = rd_idx + 7'(n);
                end
            end
            brf_pkg::MODE_FLUSH: begin
                rd_idx = rd_idx + 7'(n);
                expect_result(brf_pkg::ST_OK, '0, wr_idx - rd_idx, 1'b1);
            end
            default: expect_result(brf_pkg::ST_OK, '0, lvl, 1'b1);
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatch_count++;
    endtask

    // one request; valid stays high on return so the next request can follow at once
    task automatic send_request(input logic [2:0] mode, input logic [63:0] handle,
                                input logic [6:0] count, input logic start);
        if (source_gaps && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, count, handle};
        i_s_tuser  <= {start, mode};
        do @(posedge i_clk); while (!o_s_tready);
        predict_ring_step(mode, handle, count, start);
        requests_sent++;
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic send_batch(input int size, input int continuations);
        send_request(brf_pkg::MODE_PUSH, rand_handle(), 7'(size), 1'b1);
        for (int i = 0; i < continuations; i++)
            send_request(brf_pkg::MODE_PUSH, rand_handle(), 7'($urandom_range(0, 64)), 1'b0);
    endtask

    always @(posedge i_clk) begin : check_result
        t_ring_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata[63:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tuser !== want.status)
                    report_mismatch("status", 64'(o_m_tuser), 64'(want.status));
                if (o_m_tdata[63:0] !== want.handle)
                    report_mismatch("out_entry", o_m_tdata[63:0], want.handle);
                if (o_m_tdata[70:64] !== want.level)
                    report_mismatch("level", 64'(o_m_tdata[70:64]), 64'(want.level));
                if (o_m_tlast !== want.last)
                    report_mismatch("last", 64'(o_m_tlast), 64'(want.last));
            end
        end
    end

    initial begin
        i_m_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (sink_stalls && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic test_directed();
        send_request(MODE_QUERY, rand_handle(), 7'd0, 1'b0);
        send_request(brf_pkg::MODE_POP, '0, 7'd5, 1'b0);
        send_request(brf_pkg::MODE_PEEK, '0, 7'd0, 1'b0);
        send_request(brf_pkg::MODE_FLUSH, '0, 7'd3, 1'b1);
        send_request(brf_pkg::MODE_PUSH, '1, 7'd3, 1'b1);
        send_request(brf_pkg::MODE_PUSH, '0, 7'd0, 1'b0);
        send_request(brf_pkg::MODE_PUSH, 64'h8000_0000_0000_0001, 7'd64, 1'b0);
        send_request(brf_pkg::MODE_PEEK, '0, 7'd64, 1'b0);
        send_request(brf_pkg::MODE_POP, '0, 7'd0, 1'b0);
        send_request(brf_pkg::MODE_POP, '0, 7'd2, 1'b0);
        for (int i = 0; i < 3; i++)
            send_request(MODE_UNUSED_LO + 3'(i), rand_handle(), 7'($urandom_range(0, 64)),
                         1'($urandom));
        // batch too large for the room left: start and continuation both dropped
        send_request(brf_pkg::MODE_PUSH, rand_handle(), 7'd64, 1'b1);
        send_request(brf_pkg::MODE_PUSH, rand_handle(), 7'd0, 1'b0);
        // zero-size batch still stores
        send_request(brf_pkg::MODE_PUSH, 64'h5a5a_a5a5_0f0f_f0f0, 7'd0, 1'b1);
        send_request(brf_pkg::MODE_PUSH, rand_handle(), 7'd0, 1'b0);
        send_request(brf_pkg::MODE_PEEK, '0, 7'd1, 1'b0);
        send_request(brf_pkg::MODE_FLUSH, '0, 7'd64, 1'b0);
        send_request(brf_pkg::MODE_POP, '0, 7'd64, 1'b0);
        send_request(brf_pkg::MODE_PUSH, rand_handle(), 7'd63, 1'b1);
        send_request(MODE_QUERY, '0, 7'd0, 1'b0);
        drain_results();
    endtask

    task automatic test_full_ring();
        send_request(brf_pkg::MODE_FLUSH, '0, 7'd64, 1'b0);
        send_batch(64, 63);
        send_request(brf_pkg::MODE_PUSH, rand_handle(), 7'd0, 1'b1);
        send_request(brf_pkg::MODE_PUSH, rand_handle(), 7'd0, 1'b0);
        send_request(brf_pkg::MODE_PUSH, rand_handle(), 7'd1, 1'b1);
        send_request(brf_pkg::MODE_PEEK, '0, 7'd64, 1'b0);
        send_request(brf_pkg::MODE_POP, '0, 7'd64, 1'b0);
        send_request(MODE_QUERY, '0, 7'd0, 1'b0);
        drain_results();
    endtask

    task automatic send_random_request();
        int pick;
        int size;
        int cont;
        logic [6:0] cnt;
        pick = $urandom_range(0, 99);
        cnt  = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 64))
                                          : 7'($urandom_range(0, 8));
        if (pick < 45) begin
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            cont = size - 1;
            if ($urandom_range(0, 9) == 0)
                cont = $urandom_range(0, size + 2);
            send_batch(size, cont);
        end else if (pick < 65) begin
            send_request(brf_pkg::MODE_POP, rand_handle(), cnt, 1'($urandom));
        end else if (pick < 75) begin
            send_request(brf_pkg::MODE_PEEK, rand_handle(), cnt, 1'($urandom));
        end else if (pick < 83) begin
            send_request(brf_pkg::MODE_FLUSH, rand_handle(), cnt, 1'($urandom));
        end else if (pick < 89) begin
            send_request(MODE_QUERY, rand_handle(), cnt, 1'($urandom));
        end else if (pick < 92) begin
            send_request(MODE_UNUSED_LO + 3'($urandom_range(0, 2)), rand_handle(), cnt,
                         1'($urandom));
        end else if (pick < 97) begin
            send_request(brf_pkg::MODE_PUSH, rand_handle(), cnt, 1'b0);
        end else begin
            send_request(brf_pkg::MODE_PUSH, rand_handle(), 7'd0, 1'b1);
        end
    endtask

    task automatic test_random_mix(input int target);
        int start_count;
        start_count = requests_sent;
        while (requests_sent - start_count < target) begin
            send_random_request();
            if ($urandom_range(0, 19) == 0)
                drain_results();
        end
        drain_results();
    endtask

    task automatic test_back_to_back(input int target);
        int start_count;
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        start_count = requests_sent;
        while (requests_sent - start_count < target)
            send_random_request();
        drain_results();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = '0;
        rd_idx         = '0;
        wr_idx         = '0;
        batch_dropped  = 1'b0;
        mismatch_count = 0;
        requests_sent  = 0;
        source_gaps    = 1'b1;
        sink_stalls    = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_ring();
        test_random_mix(95);
        test_back_to_back(30);
        repeat (32) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end
endmodule
